FILE: src/pusc_pkg.sv
`default_nettype none

package pusc_pkg;

  // Per-byte outcome reported on the result channel
  typedef enum logic [2:0] {
    V_ACCEPT  = 3'd0,
    V_REJECT  = 3'd1,
    V_SKIP    = 3'd2,
    V_END_OK  = 3'd3,
    V_END_BAD = 3'd4
  } verdict_e;

  // Allowed range for the next continuation byte
  typedef enum logic [2:0] {
    TC_ANY  = 3'd0,  // 80..BF
    TC_E0   = 3'd1,  // A0..BF
    TC_ED   = 3'd2,  // 80..9F
    TC_F0   = 3'd3,  // 90..BF
    TC_F4   = 3'd4   // 80..8F
  } tail_class_e;

  typedef logic [7:0] byte_t;

  // Sequence state carried from byte to byte
  typedef struct packed {
    logic [1:0]  tails;
    tail_class_e cls;
    logic        rejected;
  } seq_state_t;

  localparam seq_state_t SeqIdle = '{tails: 2'd0, cls: TC_ANY, rejected: 1'b0};

  // Byte bounds
  localparam byte_t Terminator  = 8'h00;
  localparam byte_t PrintLo     = 8'h20;
  localparam byte_t DelByte     = 8'h7F;
  localparam byte_t Lead2Lo     = 8'hC2;
  localparam byte_t Lead2Hi     = 8'hDF;
  localparam byte_t LeadE0      = 8'hE0;
  localparam byte_t LeadE1      = 8'hE1;
  localparam byte_t LeadED      = 8'hED;
  localparam byte_t LeadEF      = 8'hEF;
  localparam byte_t LeadF0      = 8'hF0;
  localparam byte_t LeadF1      = 8'hF1;
  localparam byte_t LeadF3      = 8'hF3;
  localparam byte_t LeadF4      = 8'hF4;
  localparam byte_t TailLo      = 8'h80;
  localparam byte_t TailHi      = 8'hBF;
  localparam byte_t TailE0Lo    = 8'hA0;
  localparam byte_t TailEDHi    = 8'h9F;
  localparam byte_t TailF0Lo    = 8'h90;
  localparam byte_t TailF4Hi    = 8'h8F;

endpackage : pusc_pkg

`default_nettype wire

FILE: src/printable_utf8_string_check_core.sv
// A beat passes through the input register, then the result register.
// Throughput: one byte per cycle unless the result side stalls; the sequence
// state updates as a byte moves from the input register into the result register.
// Both registers hold a beat while the far side stalls, so no beat is lost.
// Reset (rst_ni low, asynchronous) empties both stages and clears the sequence state.
`default_nettype none

module printable_utf8_string_check_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  pusc_pkg::byte_t     data_byte_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [2:0]          verdict_o
);
  import pusc_pkg::*;

  logic       in_valid_q;
  byte_t      in_byte_q;
  logic       out_valid_q;
  verdict_e   verdict_q;
  verdict_e   verdict_d;
  seq_state_t st_q;
  seq_state_t st_d;
  logic       out_free;
  logic       advance;
  logic       in_take;

  // Handshake: the input stage drains whenever the result stage is free
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Per-byte check
  pusc_byte_check u_check (
    .data_byte_i (in_byte_q),
    .st_i        (st_q),
    .verdict_o   (verdict_d),
    .st_o        (st_d)
  );

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= data_byte_i;
    end
  end

  // Result stage and sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      st_q        <= SeqIdle;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  // Checks
  a_idle_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.tails == 2'd0) |-> (st_q.cls == TC_ANY))
    else $error("tail class set with no tails pending");

  a_rej_no_tails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.rejected |-> (st_q.tails == 2'd0))
    else $error("tails pending on a rejected string");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (verdict_d == V_END_OK || verdict_d == V_END_BAD))
    |=> (st_q.tails == 2'd0 && !st_q.rejected))
    else $error("terminator did not clear state");

  a_skip_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (verdict_d == V_SKIP || verdict_d == V_REJECT)) |=> st_q.rejected)
    else $error("rejection flag lost");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q)
    else $error("input stage emptied while stalled");

endmodule : printable_utf8_string_check_core

`default_nettype wire

FILE: src/pusc_byte_check.sv
`default_nettype none

module pusc_byte_check (
  input  pusc_pkg::byte_t      data_byte_i,
  input  pusc_pkg::seq_state_t st_i,
  output pusc_pkg::verdict_e   verdict_o,
  output pusc_pkg::seq_state_t st_o
);
  import pusc_pkg::*;

  logic tail_ok;

  // Continuation byte range for the current tail class
  always_comb begin
    unique case (st_i.cls)
      TC_E0:   tail_ok = (data_byte_i >= TailE0Lo) && (data_byte_i <= TailHi);
      TC_ED:   tail_ok = (data_byte_i >= TailLo)   && (data_byte_i <= TailEDHi);
      TC_F0:   tail_ok = (data_byte_i >= TailF0Lo) && (data_byte_i <= TailHi);
      TC_F4:   tail_ok = (data_byte_i >= TailLo)   && (data_byte_i <= TailF4Hi);
      default: tail_ok = (data_byte_i >= TailLo)   && (data_byte_i <= TailHi);
    endcase
  end

  // Verdict and next sequence state
  always_comb begin
    verdict_o = V_ACCEPT;
    st_o      = st_i;
    priority if (data_byte_i == Terminator) begin
      verdict_o = (st_i.rejected || (st_i.tails != 2'd0)) ? V_END_BAD : V_END_OK;
      st_o      = SeqIdle;
    end else if (st_i.rejected) begin
      verdict_o = V_SKIP;
    end else if (st_i.tails != 2'd0) begin
      if (!tail_ok) begin
        verdict_o   = V_REJECT;
        st_o        = SeqIdle;
        st_o.rejected = 1'b1;
      end else begin
        st_o.tails = st_i.tails - 2'd1;
        st_o.cls   = TC_ANY;
      end
    end else if ((data_byte_i >= PrintLo) && (data_byte_i < DelByte)) begin
      verdict_o = V_ACCEPT;
    end else if ((data_byte_i >= Lead2Lo) && (data_byte_i <= Lead2Hi)) begin
      st_o.tails = 2'd1;
      st_o.cls   = TC_ANY;
    end else if (data_byte_i == LeadE0) begin
      st_o.tails = 2'd2;
      st_o.cls   = TC_E0;
    end else if (data_byte_i == LeadED) begin
      st_o.tails = 2'd2;
      st_o.cls   = TC_ED;
    end else if ((data_byte_i >= LeadE1) && (data_byte_i <= LeadEF)) begin
      st_o.tails = 2'd2;
      st_o.cls   = TC_ANY;
    end else if (data_byte_i == LeadF0) begin
      st_o.tails = 2'd3;
      st_o.cls   = TC_F0;
    end else if (data_byte_i == LeadF4) begin
      st_o.tails = 2'd3;
      st_o.cls   = TC_F4;
    end else if ((data_byte_i >= LeadF1) && (data_byte_i <= LeadF3)) begin
      st_o.tails = 2'd3;
      st_o.cls   = TC_ANY;
    end else begin
      // control bytes, DEL, stray tails and bad leads
      verdict_o     = V_REJECT;
      st_o          = SeqIdle;
      st_o.rejected = 1'b1;
    end
  end

endmodule : pusc_byte_check

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import pusc_pkg::*;

  localparam int StreamBytes = 1175;  // directed bytes plus about 1150 random ones
  localparam int QuietLimit  = 2000;  // cycles with no beat on either side
  localparam int PressureAt  = 40;    // bytes accepted before the long result hold-off
  localparam int PressureLen = 100;

  logic       clk = 1'b0;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall_o;
  byte_t      data_byte;
  logic       out_valid_o;
  logic       out_stall;
  logic [2:0] verdict_o;

  byte_t byte_stream[$];
  int    calm_left = 0;
  int    quiet_cycles = 0;

  // Byte-level string checker state plus the verdicts still owed by the block
  class verdict_board;
    logic [1:0]  tails;
    tail_class_e cls;
    bit          rejected;
    verdict_e    due_q[$];
    int          noted;
    int          errors;

    function new();
      tails    = 2'd0;
      cls      = TC_ANY;
      rejected = 1'b0;
      noted    = 0;
      errors   = 0;
    endfunction

    // Work out the verdict for one accepted byte and queue it
    function void note_byte(byte_t b);
      verdict_e v;
      bit       fits;
      noted++;
      v = V_ACCEPT;
      if (b == Terminator) begin
        v        = (rejected || tails != 2'd0) ? V_END_BAD : V_END_OK;
        tails    = 2'd0;
        cls      = TC_ANY;
        rejected = 1'b0;
      end else if (rejected) begin
        v = V_SKIP;
      end else if (tails != 2'd0) begin
        case (cls)
          TC_E0:   fits = (b >= TailE0Lo) && (b <= TailHi);
          TC_ED:   fits = (b >= TailLo) && (b <= TailEDHi);
          TC_F0:   fits = (b >= TailF0Lo) && (b <= TailHi);
          TC_F4:   fits = (b >= TailLo) && (b <= TailF4Hi);
          default: fits = (b >= TailLo) && (b <= TailHi);
        endcase
        if (fits) begin
          tails = tails - 2'd1;
        end else begin
          v        = V_REJECT;
          tails    = 2'd0;
          rejected = 1'b1;
        end
        cls = TC_ANY;
      end else if (!(b >= PrintLo && b < DelByte)) begin
        // lead byte: sets the tail count and the range of the second byte
        if (b >= Lead2Lo && b <= Lead2Hi) begin
          tails = 2'd1;
          cls   = TC_ANY;
        end else if (b == LeadE0) begin
          tails = 2'd2;
          cls   = TC_E0;
        end else if (b == LeadED) begin
          tails = 2'd2;
          cls   = TC_ED;
        end else if (b >= LeadE1 && b <= LeadEF) begin
          tails = 2'd2;
          cls   = TC_ANY;
        end else if (b == LeadF0) begin
          tails = 2'd3;
          cls   = TC_F0;
        end else if (b == LeadF4) begin
          tails = 2'd3;
          cls   = TC_F4;
        end else if (b >= LeadF1 && b <= LeadF3) begin
          tails = 2'd3;
          cls   = TC_ANY;
        end else begin
          // control byte, DEL or a byte that cannot lead
          v        = V_REJECT;
          tails    = 2'd0;
          cls      = TC_ANY;
          rejected = 1'b1;
        end
      end
      due_q.push_back(v);
    endfunction

    function void check_verdict(logic [2:0] got);
      verdict_e want;
      if (due_q.size() == 0) begin
        $display("%0t: verdict %0d with nothing expected", $time, got);
        errors++;
      end else begin
        want = due_q.pop_front();
        if (got !== want) begin
          $display("%0t: verdict mismatch, expected %0d (%s), got %0d",
                   $time, want, want.name(), got);
          errors++;
        end
      end
    endfunction
  endclass

  verdict_board board;

  printable_utf8_string_check_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .verdict_o   (verdict_o)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Gap before the next byte: mostly none, some short, a few long, with calm runs
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm_left = $urandom_range(20, 60);
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer each byte until it is taken; valid stays high across back-to-back beats
  task automatic send_stream();
    int gap;
    foreach (byte_stream[i]) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid  <= 1'b1;
      data_byte <= byte_stream[i];
      @(posedge clk);
      while (in_stall_o) @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // Beat monitor on both channels, plus the watchdog
  always @(posedge clk) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (out_valid_o && !out_stall) begin
        board.check_verdict(verdict_o);
        quiet_cycles = 0;
      end
      if (in_valid && !in_stall_o) begin
        board.note_byte(data_byte);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // Result side: one long hold-off to back the block up, then random stalls
  initial begin
    int r;
    out_stall = 1'b0;
    while (board == null || board.noted < PressureAt) @(posedge clk);
    out_stall <= 1'b1;
    repeat (PressureLen) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else if (r < 92) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(8, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    byte_t directed[];
    byte_t seq[4];
    byte_t lead;
    byte_t lo;
    byte_t hi;
    int    units;
    int    pick;
    int    ntails;
    int    cut;
    bit    noisy;

    directed = '{
      8'h20, 8'h7E, 8'h00,                 // printable bounds, string ends valid
      8'h1F, 8'hFF, 8'h00,                 // control byte, then skip, ends invalid
      8'hC2, 8'hBF, 8'hDF, 8'h80, 8'h00,   // two-byte leads at both ends
      8'hF4, 8'h8F, 8'hBF, 8'h80, 8'h00,   // F4 with its top second byte
      8'hE0, 8'h9F, 8'h00,                 // bad tail after E0
      8'hF0, 8'h90, 8'h00,                 // truncated four-byte sequence
      8'h7F, 8'h00,                        // DEL
      8'hED, 8'hA0, 8'h00                  // surrogate range after ED
    };

    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    data_byte = '0;
    board     = new();

    foreach (directed[i]) byte_stream.push_back(directed[i]);

    // Random strings: mostly well-formed, a quarter of them carry noise and broken sequences
    while (byte_stream.size() < StreamBytes) begin
      units = $urandom_range(0, 10);
      noisy = ($urandom_range(0, 3) == 0);
      repeat (units) begin
        pick = $urandom_range(0, 99);
        if (noisy && pick < 10) begin
          byte_stream.push_back(byte_t'($urandom_range(1, 255)));
        end else if (pick < 50) begin
          byte_stream.push_back(byte_t'($urandom_range(8'h20, 8'h7E)));
        end else begin
          lo     = TailLo;
          hi     = TailHi;
          ntails = 3;
          case ($urandom_range(0, 6))
            0: begin
              lead   = byte_t'($urandom_range(8'hC2, 8'hDF));
              ntails = 1;
            end
            1: begin
              lead   = LeadE0;
              lo     = TailE0Lo;
              ntails = 2;
            end
            2: begin
              lead   = byte_t'($urandom_range(8'hE1, 8'hEF));
              if (lead == LeadED) lead = LeadEF;
              ntails = 2;
            end
            3: begin
              lead   = LeadED;
              hi     = TailEDHi;
              ntails = 2;
            end
            4: begin
              lead = LeadF0;
              lo   = TailF0Lo;
            end
            5: lead = byte_t'($urandom_range(8'hF1, 8'hF3));
            default: begin
              lead = LeadF4;
              hi   = TailF4Hi;
            end
          endcase
          seq[0] = lead;
          seq[1] = byte_t'($urandom_range(lo, hi));
          seq[2] = byte_t'($urandom_range(8'h80, 8'hBF));
          seq[3] = byte_t'($urandom_range(8'h80, 8'hBF));
          cut    = ntails + 1;
          // broken sequence: one byte after the lead replaced, or cut short
          if (noisy && pick >= 85) begin
            if ($urandom_range(0, 1) == 1) begin
              seq[$urandom_range(1, ntails)] = byte_t'($urandom_range(1, 255));
            end else begin
              cut = $urandom_range(1, ntails);
            end
          end
          for (int k = 0; k < cut; k++) byte_stream.push_back(seq[k]);
        end
      end
      byte_stream.push_back(Terminator);
    end

    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    send_stream();
    while (board.due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/pusc_pkg.sv
src/pusc_byte_check.sv
src/printable_utf8_string_check_core.sv
sim/tb.sv
